FILE: design/fre_pkg.sv
// Shared types and constants for the frame rate estimator.
package fre_pkg;

    localparam int          CFG_IDX_W    = 2;
    localparam int          RATE_W       = 32;
    localparam int          WEIGHT_W     = 16;
    localparam int          RATIO_W      = 8;
    localparam int          STATUS_W     = 2;
    localparam int          USEC_BITS    = 20;
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
    localparam logic [31:0] RATE_MAX     = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_RATIO = 2'd2;

    // reset values of the configuration
    localparam logic [RATE_W-1:0]   INITIAL_RATE_RST  = 32'd40960;
    localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 16'd3277;
    localparam logic [RATIO_W-1:0]  OUTLIER_RATIO_RST = 8'd20;

    // sample status codes
    localparam logic [STATUS_W-1:0] ST_FIRST  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_CHK,
        S_BLEND,
        S_UPD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;      // capture a new event
        logic div_step;   // one quotient bit
        logic mul;        // saturate quotient, form band products
        logic blend;      // form weighted difference
        logic update;     // commit new estimate
        logic load_out;   // move result into output register
    } t_cmd;

    typedef struct packed {
        logic skip;       // first event or zero interval, no divide
        logic div_last;   // final quotient bit in this cycle
        logic pass;       // raw rate inside outlier band
    } t_sts;

endpackage

FILE: design/fre_ctrl.sv
// Sequencer for the frame rate estimator: state machine and output valid.
module fre_ctrl
    import fre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.skip ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_CHK;
            S_CHK:   n_state = i_sts.pass ? S_BLEND : S_OUT;
            S_BLEND: n_state = S_UPD;
            S_UPD:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.start  = i_in_valid;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_MUL:   o_cmd.mul      = 1'b1;
            S_CHK:   o_cmd          = '0;
            S_BLEND: o_cmd.blend    = 1'b1;
            S_UPD:   o_cmd.update   = 1'b1;
            S_OUT:   o_cmd.load_out = out_free;
            default: o_cmd          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/fre_dp.sv
// Datapath: interval, serial divider, outlier band test and smoothing update.
module fre_dp
    import fre_pkg::*;
#(
    parameter int TIME_WIDTH     = 32,
    parameter int RATE_FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [31:0]          i_frame_time,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_wr_data,
    output logic [RATE_W-1:0]    o_rate_estimate,
    output logic [RATE_W-1:0]    o_raw_rate,
    output logic [STATUS_W-1:0]  o_sample_status
);

    localparam int TW    = TIME_WIDTH;
    localparam int NUM_W = USEC_BITS + RATE_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] NUM = NUM_W'(USEC_PER_SEC) << RATE_FRAC_BITS;
    localparam int PROD_W = 2 * RATE_W + RATIO_W - RATE_W;  // ratio x rate
    localparam int BL_W   = RATE_W + 1 + WEIGHT_W + 1;      // diff x weight

    // event state
    logic [TW-1:0]       r_prev;
    logic                r_have_prev;
    logic [RATE_W-1:0]   r_est;
    logic [WEIGHT_W-1:0] r_weight;
    logic [RATIO_W-1:0]  r_ratio;

    // per-event working registers
    logic [TW-1:0]       r_dt;
    logic [TW-1:0]       r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [RATE_W-1:0]   r_raw;
    logic [STATUS_W-1:0] r_status;
    logic [PROD_W-1:0]   r_p_raw;
    logic [PROD_W-1:0]   r_p_est;
    logic signed [BL_W-1:0] r_prod;

    // output register
    logic [RATE_W-1:0]   r_o_est;
    logic [RATE_W-1:0]   r_o_raw;
    logic [STATUS_W-1:0] r_o_status;

    logic [TW-1:0]          now;
    logic [TW-1:0]          dt_in;
    logic [TW:0]            trial;
    logic [TW:0]            trial_sub;
    logic                   q_bit;
    logic [RATE_W-1:0]      raw_sat;
    logic signed [RATE_W:0] diff;
    logic signed [WEIGHT_W:0] wt;
    logic signed [BL_W-1:0] prod_c;
    logic signed [RATE_W+1:0] delta;
    logic signed [RATE_W+2:0] est_next;
    logic [RATE_W-1:0]      est_clamp;

    assign now   = TW'(i_frame_time);
    assign dt_in = now - r_prev;

    // restoring divide, one quotient bit per cycle; remainder stays below dt
    assign trial     = {r_rem, r_quo[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_dt};
    assign q_bit     = !trial_sub[TW];

    assign raw_sat = (64'(r_quo) > 64'(RATE_MAX)) ? RATE_MAX : RATE_W'(r_quo);

    assign diff   = $signed({1'b0, r_raw}) - $signed({1'b0, r_est});
    assign wt     = $signed({1'b0, r_weight});
    assign prod_c = BL_W'(diff) * BL_W'(wt);

    // arithmetic shift gives the floor for negative products
    assign delta    = (RATE_W+2)'(r_prod >>> WEIGHT_W);
    assign est_next = $signed({3'b000, r_est}) + (RATE_W+3)'(delta);

    always_comb begin
        if (est_next < 0) begin
            est_clamp = '0;
        end else if (est_next[RATE_W+2:RATE_W] != 3'b000) begin
            est_clamp = RATE_MAX;
        end else begin
            est_clamp = est_next[RATE_W-1:0];
        end
    end

    assign o_sts.skip     = !r_have_prev || (dt_in == '0);
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.pass     = (r_p_raw > PROD_W'(r_est)) && (PROD_W'(r_raw) < r_p_est);

    // state that reset and configuration touch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_est       <= INITIAL_RATE_RST;
            r_weight    <= SMOOTH_WEIGHT_RST;
            r_ratio     <= OUTLIER_RATIO_RST;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_INITIAL_RATE: begin
                        r_est       <= i_cfg_wr_data;
                        r_have_prev <= 1'b0;
                    end
                    CFG_SMOOTH_WEIGHT: r_weight <= i_cfg_wr_data[WEIGHT_W-1:0];
                    CFG_OUTLIER_RATIO: r_ratio  <= i_cfg_wr_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_prev      <= now;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.update) begin
                r_est <= est_clamp;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dt     <= dt_in;
            r_rem    <= '0;
            r_quo    <= NUM;
            r_cnt    <= CNT_W'(NUM_W - 1);
            r_raw    <= '0;
            r_status <= r_have_prev ? ST_REJECT : ST_FIRST;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? trial_sub[TW-1:0] : trial[TW-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul) begin
            r_raw   <= raw_sat;
            r_p_raw <= PROD_W'(r_ratio) * PROD_W'(raw_sat);
            r_p_est <= PROD_W'(r_ratio) * PROD_W'(r_est);
        end
        if (i_cmd.blend) begin
            r_prod <= prod_c;
        end
        if (i_cmd.update) begin
            r_status <= ST_ACCEPT;
        end
        if (i_cmd.load_out) begin
            r_o_est    <= r_est;
            r_o_raw    <= r_raw;
            r_o_status <= r_status;
        end
    end

    assign o_rate_estimate = r_o_est;
    assign o_raw_rate      = r_o_raw;
    assign o_sample_status = r_o_status;

endmodule

FILE: design/frame_rate_estimator.sv
// Top level of the frame rate estimator: sequencer plus datapath.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_frame_time
//  result    out        o_out_valid / i_out_stall  o_rate_estimate, o_raw_rate,
//                                                  o_sample_status
//  config    in         i_cfg_wr_en                i_cfg_index, i_cfg_wr_data
//
// A first event or a zero interval skips the divider and is loaded for output.
// Other events run the serial divider, one quotient bit per cycle, then a
// band product step, the band test and, for a rate in band, blend and update.
// One event is in flight at a time; the next is taken while a result waits.
// Synchronous active-low reset restores the configuration reset values.
// A stalled result holds in the output register; the next result waits for it.
module frame_rate_estimator
    import fre_pkg::*;
#(
    parameter int TIME_WIDTH     = 32,
    parameter int RATE_FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_frame_time,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [RATE_W-1:0]    o_rate_estimate,
    output logic [RATE_W-1:0]    o_raw_rate,
    output logic [STATUS_W-1:0]  o_sample_status,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    fre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fre_dp #(
        .TIME_WIDTH     (TIME_WIDTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_frame_time    (i_frame_time),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_rate_estimate (o_rate_estimate),
        .o_raw_rate      (o_raw_rate),
        .o_sample_status (o_sample_status)
    );

endmodule

FILE: design/fre_checker.sv
// Port-level checks for the frame rate estimator, bound to the top level.
module fre_checker
    import fre_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [RATE_W-1:0]   o_raw_rate,
    input logic [STATUS_W-1:0] o_sample_status
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one event at a time: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before event finished");

    // first event carries no raw rate
    a_first_raw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sample_status == ST_FIRST) |-> (o_raw_rate == '0))
        else $error("first event shows a raw rate");

    // an accepted sample must have a nonzero raw rate
    a_accept_raw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sample_status == ST_ACCEPT) |-> (o_raw_rate != '0))
        else $error("accepted sample with zero raw rate");

    // status code is never the unused value
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_status == ST_FIRST || o_sample_status == ST_ACCEPT
                         || o_sample_status == ST_REJECT))
        else $error("bad sample status");

endmodule

bind frame_rate_estimator fre_checker u_fre_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_raw_rate      (o_raw_rate),
    .o_sample_status (o_sample_status)
);

FILE: sim/tb.sv
// Testbench for frame_rate_estimator: directed and random frame events checked by a predictor.
module tb
    import fre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD      = 10;
    localparam int          RST_CYCLES      = 7;
    localparam int          RATE_FRAC       = 12;
    localparam int          TAIL_CYCLES     = 64;
    localparam int          LONG_HOLD       = 400;
    localparam int          N_PHASES        = 9;
    localparam int          ITEMS_PER_PHASE = 110;
    localparam int          MAX_REPORTS     = 40;
    localparam longint      TIMEOUT_NS      = 15_000_000;
    localparam logic [63:0] RATE_NUM        = {32'd0, USEC_PER_SEC} << RATE_FRAC;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [RATE_W-1:0]   est;
        logic [RATE_W-1:0]   raw;
        logic [STATUS_W-1:0] status;
    } t_rate_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [31:0]          i_frame_time    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [RATE_W-1:0]    o_rate_estimate;
    logic [RATE_W-1:0]    o_raw_rate;
    logic [STATUS_W-1:0]  o_sample_status;
    logic                 i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [RATE_W-1:0]    i_cfg_wr_data   = '0;

    // predictor state and configuration copy
    logic [31:0]          mdl_prev_time   = '0;
    logic                 mdl_have_prev   = 1'b0;
    logic [RATE_W-1:0]    mdl_est         = INITIAL_RATE_RST;
    logic [WEIGHT_W-1:0]  cfg_weight      = SMOOTH_WEIGHT_RST;
    logic [RATIO_W-1:0]   cfg_ratio       = OUTLIER_RATIO_RST;

    t_rate_result         pending_rates[$];
    int                   err_count       = 0;

    // idling controls
    logic                 tx_idle_en      = 1'b1;
    logic                 rx_idle_en      = 1'b1;
    int                   hold_reqs       = 0;
    int                   hold_seen       = 0;
    int                   stall_left      = 0;

    frame_rate_estimator #(
        .TIME_WIDTH     (32),
        .RATE_FRAC_BITS (RATE_FRAC)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_frame_time    (i_frame_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rate_estimate (o_rate_estimate),
        .o_raw_rate      (o_raw_rate),
        .o_sample_status (o_sample_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (err_count < MAX_REPORTS) begin
            $display("MISMATCH %0t ns: %s", $time, what);
        end
        err_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic logic [RATE_W-1:0] interval_to_rate(input logic [31:0] dt);
        logic [63:0] q;
        q = RATE_NUM / {32'd0, dt};
        return (q > {32'd0, RATE_MAX}) ? RATE_MAX : q[RATE_W-1:0];
    endfunction

    function automatic logic rate_in_band(input logic [RATE_W-1:0] raw);
        logic [63:0] r;
        r = {56'd0, cfg_ratio};
        return (r * raw > {32'd0, mdl_est}) && ({32'd0, raw} < r * mdl_est);
    endfunction

    function automatic logic [RATE_W-1:0] blend_rate(input logic [RATE_W-1:0] est,
                                                     input logic [RATE_W-1:0] raw,
                                                     input logic [WEIGHT_W-1:0] w);
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        logic signed [63:0] nxt;
        diff = $signed({32'd0, raw}) - $signed({32'd0, est});
        prod = diff * $signed({48'd0, w});
        // arithmetic shift floors negative steps
        nxt  = $signed({32'd0, est}) + (prod >>> 16);
        if (nxt < 0) return '0;
        if (nxt > $signed({32'd0, RATE_MAX})) return RATE_MAX;
        return nxt[RATE_W-1:0];
    endfunction

    task automatic predict_rate_event(input logic [31:0] t, output t_rate_result res);
        logic [31:0] dt;
        res.raw = '0;
        if (!mdl_have_prev) begin
            res.status    = ST_FIRST;
            mdl_have_prev = 1'b1;
        end else begin
            dt = t - mdl_prev_time;
            if (dt == 0) begin
                res.status = ST_REJECT;
            end else begin
                res.raw = interval_to_rate(dt);
                if (rate_in_band(res.raw)) begin
                    mdl_est    = blend_rate(mdl_est, res.raw, cfg_weight);
                    res.status = ST_ACCEPT;
                end else begin
                    res.status = ST_REJECT;
                end
            end
        end
        mdl_prev_time = t;
        res.est       = mdl_est;
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin : check_results
        t_rate_result want;
        if (i_rst_n && $isunknown(o_out_valid)) begin
            report_mismatch("o_out_valid unknown");
        end else if (i_rst_n && o_out_valid && i_out_stall == 1'b0) begin
            if (pending_rates.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_rates.pop_front();
                if (o_rate_estimate !== want.est)
                    report_mismatch($sformatf("rate_estimate %h, want %h",
                                              o_rate_estimate, want.est));
                if (o_raw_rate !== want.raw)
                    report_mismatch($sformatf("raw_rate %h, want %h", o_raw_rate, want.raw));
                if (o_sample_status !== want.status)
                    report_mismatch($sformatf("sample_status %0d, want %0d",
                                              o_sample_status, want.status));
            end
        end
    end

    // ---------------- receiver stalls ----------------

    always @(posedge i_clk) begin : drive_out_stall
        int unsigned p;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen   <= hold_reqs;
            i_out_stall <= 1'b1;
            stall_left  <= LONG_HOLD - 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!rx_idle_en) begin
            i_out_stall <= 1'b0;
        end else begin
            p = $urandom_range(0, 99);
            if (p < 55) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(0, 7);
            end else if (p < 92) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(9, 59);
            end
        end
    end

    // ---------------- sender side ----------------

    function automatic int unsigned pick_gap();
        int unsigned p;
        if (!tx_idle_en) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 80);
    endfunction

    task automatic send_frame(input logic [31:0] t);
        int unsigned  gap;
        t_rate_result want;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_time <= t;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_rate_event(t, want);
        pending_rates.push_back(want);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        drain_results();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INITIAL_RATE: begin
                mdl_est       = val;
                mdl_have_prev = 1'b0;
            end
            CFG_SMOOTH_WEIGHT: cfg_weight = val[WEIGHT_W-1:0];
            CFG_OUTLIER_RATIO: cfg_ratio = val[RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly intervals near the current estimate, plus outliers, repeats and noise.
    function automatic logic [31:0] pick_frame_time();
        logic [63:0] nominal;
        logic [63:0] span;
        logic [63:0] dt;
        int unsigned p;
        p = $urandom_range(0, 99);
        if (!mdl_have_prev || p < 8) return $urandom;
        if (p < 13) return mdl_prev_time;
        nominal = (mdl_est == 0) ? 64'($urandom) : RATE_NUM / {32'd0, mdl_est};
        if (nominal == 0) nominal = 1;
        if (p < 20) begin
            dt = nominal * $urandom_range(10, 300);
        end else if (p < 27) begin
            dt = nominal / $urandom_range(10, 300) + 1;
        end else begin
            span = nominal / 4;
            dt   = nominal - span + $urandom_range(0, 32'(span * 2));
        end
        return mdl_prev_time + dt[31:0];
    endfunction

    // fresh estimate, first event, then one interval
    task automatic probe_interval(input logic [RATE_W-1:0] init_rate, input logic [31:0] dt);
        logic [31:0] t0;
        write_reg(CFG_INITIAL_RATE, init_rate);
        t0 = $urandom;
        send_frame(t0);
        send_frame(t0 + dt);
    endtask

    // ---------------- tests ----------------

    task automatic test_first_and_zero();
        send_frame(32'h0000_0000);
        send_frame(32'h0000_0000);      // zero interval
        send_frame(32'd100000);         // 10 fps, matches reset estimate
        send_frame(32'hFFFF_FFFF);      // very long interval
        send_frame(32'h0000_0F00);      // wraps past zero
        send_frame(32'h0000_0F01);      // 1 us: largest raw rate
    endtask

    task automatic test_band_edges();
        probe_interval(INITIAL_RATE_RST, 32'd5000);     // raw == ratio*est, rejected
        probe_interval(INITIAL_RATE_RST, 32'd5001);
        probe_interval(INITIAL_RATE_RST, 32'd2000000);  // ratio*raw == est, rejected
        probe_interval(INITIAL_RATE_RST, 32'd1999000);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_SMOOTH_WEIGHT, 32'd0);
        probe_interval(INITIAL_RATE_RST, 32'd80000);    // accepted, estimate holds
        write_reg(CFG_SMOOTH_WEIGHT, 32'h0000_FFFF);
        probe_interval(INITIAL_RATE_RST, 32'd120000);   // negative step rounds down
        write_reg(CFG_OUTLIER_RATIO, 32'd0);
        probe_interval(INITIAL_RATE_RST, 32'd100000);   // empty band
        write_reg(CFG_OUTLIER_RATIO, 32'd255);
        probe_interval(32'd0, 32'd100000);              // zero estimate
        write_reg(CFG_OUTLIER_RATIO, 32'd2);
        probe_interval(RATE_MAX, 32'd1);
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);       // must leave state alone
        send_frame(mdl_prev_time + 32'd1);
        write_reg(CFG_SMOOTH_WEIGHT, 32'(SMOOTH_WEIGHT_RST));
        write_reg(CFG_OUTLIER_RATIO, 32'(OUTLIER_RATIO_RST));
    endtask

    task automatic test_backpressure();
        drain_results();
        tx_idle_en = 1'b0;
        @(posedge i_clk);
        hold_reqs <= hold_reqs + 1;
        repeat (8) send_frame(pick_frame_time());
        drain_results();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [RATE_W-1:0]   init_rate;
        logic [WEIGHT_W-1:0] w;
        logic [RATIO_W-1:0]  r;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin init_rate = INITIAL_RATE_RST; w = SMOOTH_WEIGHT_RST;
                         r = OUTLIER_RATIO_RST; end
                1: begin init_rate = INITIAL_RATE_RST; w = 16'hFFFF; r = 8'd255; end
                2: begin init_rate = INITIAL_RATE_RST; w = 16'd0; r = 8'd20; end
                3: begin init_rate = INITIAL_RATE_RST; w = SMOOTH_WEIGHT_RST; r = 8'd1; end
                4: begin init_rate = 32'd1; w = 16'd30000; r = 8'd255; end
                5: begin init_rate = RATE_MAX; w = 16'($urandom); r = 8'd2; end
                default: begin
                    init_rate = $urandom >> $urandom_range(0, 31);
                    w         = 16'($urandom);
                    r         = 8'($urandom);
                end
            endcase
            write_reg(CFG_SMOOTH_WEIGHT, {16'd0, w});
            write_reg(CFG_OUTLIER_RATIO, {24'd0, r});
            write_reg(CFG_INITIAL_RATE, init_rate);
            // one phase runs flat out on both sides
            tx_idle_en = (ph != 1);
            rx_idle_en <= (ph != 1);
            repeat (ITEMS_PER_PHASE) send_frame(pick_frame_time());
        end
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_and_zero();
        test_band_edges();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/fre_pkg.sv
design/fre_ctrl.sv
design/fre_dp.sv
design/frame_rate_estimator.sv
design/fre_checker.sv
sim/tb.sv
